// ===== rtl/lbfs_pkg.sv =====
// Package: widths and constants for the load based frequency selector.
package lbfs_pkg;
	localparam int NUM_CORES_DEF   = 8;
	localparam int TABLE_DEPTH_DEF = 16;
	localparam int FREQ_W = 22;
	localparam int CNT_W  = 64;
	localparam int DELTA_W = 32;
	localparam int LOAD_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 22;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OWNER     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN = 2'd3;
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TABLE  = 1'b1;
	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
	localparam int PCT = 100;

	typedef struct packed {
		logic                 func;
		logic [2:0]           core_index;
		logic [CNT_W-1:0]     wall_time_now;
		logic [CNT_W-1:0]     idle_time_now;
		logic                 core_enabled;
		logic                 round_last;
		logic [FREQ_W-1:0]    cur_freq_khz;
		logic [3:0]           table_index;
		logic [FREQ_W-1:0]    table_freq_khz;
		logic                 table_entry_valid;
	} lbfs_in_t;

	typedef struct packed {
		logic [FREQ_W-1:0] next_freq_khz;
		logic              change_request;
		logic [LOAD_W-1:0] peak_load;
	} lbfs_out_t;
endpackage

// ===== rtl/lbfs_in_if.sv =====
// Interface: sample and table write channel.
interface lbfs_in_if import lbfs_pkg::*; ();
	logic     valid;
	logic     ready;
	lbfs_in_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lbfs_out_if.sv =====
// Interface: frequency choice channel.
interface lbfs_out_if import lbfs_pkg::*; ();
	logic      valid;
	logic      ready;
	lbfs_out_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/load_based_frequency_selector.sv =====
// Top level: load based frequency selector with bit-serial load division.
// Steps: a table write is stored on acceptance. A core sample then passes delta,
// divide setup, 39 restoring division steps and peak merge; a sample that forms
// no load passes delta and setup only. A last sample goes on to scale/clamp, a walk
// of up to TABLE_DEPTH table entries, pick and output before its result shows.
// One transaction at a time; reset (arst_n low) clears counters, peak, valid bits, config.
module load_based_frequency_selector
	import lbfs_pkg::*;
#(
	parameter int NUM_CORES   = NUM_CORES_DEF,
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	lbfs_in_if.sink               in_ch,
	lbfs_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
	localparam int TIDX_W = $clog2(TABLE_DEPTH);
	localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(DELTA_W + 1);
	localparam int RECIP_SH = FREQ_W + $clog2(PCT);
	localparam int RECIP_W  = FREQ_W + 1;
	localparam longint RECIP = ((64'd1 << RECIP_SH) + PCT - 1) / PCT;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DELTA, ST_DIV, ST_PEAK, ST_SCALE, ST_CLAMP, ST_WALK,
		ST_PICK, ST_OUT
	} state_t;

	state_t state_q;
	logic [FREQ_W-1:0] min_q, max_q;
	logic [2:0]        owner_q;
	logic [4:0]        tlen_q;
	logic [CNT_W-1:0]  prev_wall_q [NUM_CORES];
	logic [CNT_W-1:0]  prev_idle_q [NUM_CORES];
	logic [FREQ_W-1:0] fstore_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] fvalid_q;
	logic [LOAD_W-1:0] peak_q;
	lbfs_in_t          item_q;
	logic [DELTA_W-1:0] wall_q, busy_q;
	logic [DELTA_W+LOAD_W-1:0] num_q;
	logic [DELTA_W:0]  rem_q;
	logic [LOAD_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              do_load_q;
	logic [FREQ_W-1:0] target_q, lower_q, upper_q, pick_q;
	logic              done_q, exact_q;
	logic [TCNT_W-1:0] walk_q;
	logic [TCNT_W-1:0] n_lim;
	logic [FREQ_W+RECIP_W-1:0] recip_prod;
	logic [FREQ_W-1:0] max_div;
	logic [FREQ_W-1:0] max_div_q;
	logic [FREQ_W+LOAD_W-1:0] prod;
	logic [FREQ_W-1:0] t_min;
	logic [DELTA_W:0]  rem_sh;
	logic [CORE_W-1:0] core_i;
	logic              core_ok;
	logic [FREQ_W-1:0] f_walk;
	lbfs_out_t         out_q;
	logic              out_valid_q;

	assign in_ch.ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	assign core_i  = CORE_W'(item_q.core_index);
	assign core_ok = ({29'd0, item_q.core_index} < 32'(NUM_CORES));
	assign n_lim   = (32'(tlen_q) > 32'(TABLE_DEPTH)) ? TCNT_W'(TABLE_DEPTH)
		: TCNT_W'(tlen_q);
	// max/100 by reciprocal multiplication, exact for every 22-bit value
	assign recip_prod = (FREQ_W+RECIP_W)'(max_q) * (FREQ_W+RECIP_W)'(RECIP);
	assign max_div = FREQ_W'(recip_prod >> RECIP_SH);
	assign prod    = (FREQ_W+LOAD_W)'(peak_q) * (FREQ_W+LOAD_W)'(max_div_q);
	assign t_min   = (FREQ_W'(prod) < min_q) ? min_q : FREQ_W'(prod);
	assign rem_sh  = {rem_q[DELTA_W-1:0], num_q[DELTA_W+LOAD_W-1]};
	assign f_walk  = fstore_q[walk_q[TIDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= FREQ_MAX;
			owner_q <= '0;
			tlen_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_FREQ:  min_q <= cfg_data;
				CFG_MAX_FREQ:  max_q <= cfg_data;
				CFG_OWNER:     owner_q <= cfg_data[2:0];
				CFG_TABLE_LEN: tlen_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_div_q <= FREQ_W'(FREQ_MAX / PCT);
		else
			max_div_q <= max_div;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready
				&& in_ch.data.func == FUNC_TABLE
				&& 32'(in_ch.data.table_index) < 32'(TABLE_DEPTH))
			fstore_q[TIDX_W'(in_ch.data.table_index)] <= in_ch.data.table_freq_khz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fvalid_q <= '0;
			peak_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_CORES; i++) begin
				prev_wall_q[i] <= '0;
				prev_idle_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						item_q <= in_ch.data;
						if (in_ch.data.func == FUNC_TABLE) begin
							if (32'(in_ch.data.table_index) < 32'(TABLE_DEPTH))
								fvalid_q[TIDX_W'(in_ch.data.table_index)]
									<= in_ch.data.table_entry_valid;
						end else if (in_ch.data.cur_freq_khz == '0) begin
							if (in_ch.data.round_last)
								peak_q <= '0;
						end else begin
							state_q <= ST_DELTA;
						end
					end
				end
				ST_DELTA: begin
					// truncated deltas; owner counters update before skip test
					do_load_q <= item_q.core_enabled && core_ok &&
						(DELTA_W'(item_q.wall_time_now - prev_wall_q[core_i]) != '0) &&
						(DELTA_W'(item_q.wall_time_now - prev_wall_q[core_i]) >=
						DELTA_W'(item_q.idle_time_now - prev_idle_q[core_i]));
					if (item_q.core_enabled && core_ok) begin
						wall_q <= DELTA_W'(item_q.wall_time_now - prev_wall_q[core_i]);
						busy_q <= DELTA_W'(item_q.wall_time_now - prev_wall_q[core_i])
							- DELTA_W'(item_q.idle_time_now - prev_idle_q[core_i]);
						if ({29'd0, item_q.core_index} == {29'd0, owner_q}) begin
							prev_wall_q[core_i] <= item_q.wall_time_now;
							prev_idle_q[core_i] <= item_q.idle_time_now;
						end
					end
					state_q <= ST_PEAK;
					step_q <= '0;
				end
				ST_PEAK: begin
					// start the serial division of busy*100 by wall, or skip it when no load forms
					if (do_load_q) begin
						num_q <= (DELTA_W+LOAD_W)'(busy_q) * (DELTA_W+LOAD_W)'(PCT);
						rem_q <= '0;
						quo_q <= '0;
						step_q <= '0;
						do_load_q <= 1'b0;
						state_q <= ST_DIV;
					end else begin
						state_q <= item_q.round_last ? ST_SCALE : ST_IDLE;
					end
				end
				ST_DIV: begin
					// one quotient bit per cycle over DELTA_W+LOAD_W numerator bits
					num_q <= {num_q[DELTA_W+LOAD_W-2:0], 1'b0};
					if (rem_sh >= {1'b0, wall_q}) begin
						rem_q <= rem_sh - {1'b0, wall_q};
						quo_q <= {quo_q[LOAD_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[LOAD_W-2:0], 1'b0};
					end
					if (32'(step_q) == DELTA_W + LOAD_W - 1) begin
						state_q <= ST_CLAMP;
					end
					step_q <= step_q + 1'b1;
				end
				ST_CLAMP: begin
					// quotient done: merge into peak
					if (quo_q > peak_q)
						peak_q <= quo_q;
					state_q <= item_q.round_last ? ST_SCALE : ST_IDLE;
				end
				ST_SCALE: begin
					// min first, then max, so max wins on a crossed range
					target_q <= (t_min > max_q) ? max_q : t_min;
					lower_q <= '0;
					upper_q <= '0;
					done_q <= 1'b0;
					exact_q <= 1'b0;
					walk_q <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_q >= n_lim || done_q) begin
						state_q <= ST_PICK;
					end else begin
						if (fvalid_q[walk_q[TIDX_W-1:0]]) begin
							if (f_walk == target_q) begin
								exact_q <= 1'b1;
								done_q <= 1'b1;
							end else if (f_walk < target_q) begin
								lower_q <= f_walk;
							end else begin
								upper_q <= f_walk;
								done_q <= 1'b1;
							end
						end
						walk_q <= walk_q + 1'b1;
					end
				end
				ST_PICK: begin
					if (exact_q)
						pick_q <= target_q;
					else if (item_q.cur_freq_khz >= lower_q
							&& item_q.cur_freq_khz <= upper_q)
						pick_q <= item_q.cur_freq_khz;
					else
						pick_q <= upper_q;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_q.next_freq_khz <= pick_q;
					out_q.change_request <= (pick_q != item_q.cur_freq_khz)
						&& (pick_q != '0);
					out_q.peak_load <= peak_q;
					out_valid_q <= 1'b1;
					peak_q <= '0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== verif/lbfs_checker.sv =====
// Checker: predicts frequency choices from observed transactions and compares them.
module lbfs_checker
	import lbfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	lbfs_in_if.sink               in_mon,
	lbfs_out_if.sink              out_mon,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CORES = NUM_CORES_DEF;
	localparam int DEPTH = TABLE_DEPTH_DEF;

	logic [FREQ_W-1:0] lo_khz, hi_khz, freq_tab [DEPTH];
	logic [2:0]        owner;
	logic [4:0]        tab_len;
	logic [CNT_W-1:0]  last_wall [CORES], last_idle [CORES];
	logic [LOAD_W-1:0] peak;
	logic              tab_ok [DEPTH];
	lbfs_out_t         choice_q [$];

	assign pending = choice_q.size();

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("%0t lbfs mismatch: %s got %0d want %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	function automatic logic [FREQ_W-1:0] snap_freq(input logic [31:0] target,
			input logic [FREQ_W-1:0] cur);
		logic [31:0] below, above;
		int          n;
		below = 0;
		above = 0;
		if (target < 32'(lo_khz)) target = 32'(lo_khz);
		if (target > 32'(hi_khz)) target = 32'(hi_khz);
		n = (tab_len > DEPTH) ? DEPTH : tab_len;
		for (int i = 0; i < n; i++) begin
			if (!tab_ok[i]) continue;
			if (32'(freq_tab[i]) == target) return freq_tab[i];
			if (32'(freq_tab[i]) < target) begin
				below = 32'(freq_tab[i]);
			end else begin
				above = 32'(freq_tab[i]);
				break;
			end
		end
		if (32'(cur) >= below && 32'(cur) <= above) return cur;
		return above[FREQ_W-1:0];
	endfunction

	task automatic take_sample(input lbfs_in_t t);
		logic [DELTA_W-1:0] dw, di;
		logic [63:0]        load;
		lbfs_out_t          r;
		if (t.func == FUNC_TABLE) begin
			freq_tab[t.table_index] = t.table_freq_khz;
			tab_ok[t.table_index] = t.table_entry_valid;
			return;
		end
		if (t.cur_freq_khz == 0) begin
			if (t.round_last) peak = 0;
			return;
		end
		if (t.core_enabled) begin
			dw = DELTA_W'(t.wall_time_now - last_wall[t.core_index]);
			di = DELTA_W'(t.idle_time_now - last_idle[t.core_index]);
			if (t.core_index == owner) begin
				last_wall[t.core_index] = t.wall_time_now;
				last_idle[t.core_index] = t.idle_time_now;
			end
			if (dw != 0 && dw >= di) begin
				load = (64'(dw - di) * 64'(PCT)) / 64'(dw);
				if (load > 64'(peak)) peak = load[LOAD_W-1:0];
			end
		end
		if (!t.round_last) return;
		r.next_freq_khz = snap_freq(32'(peak) * 32'(hi_khz / PCT), t.cur_freq_khz);
		r.change_request = r.next_freq_khz != t.cur_freq_khz && r.next_freq_khz != 0;
		r.peak_load = peak;
		choice_q.push_back(r);
		peak = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_khz = 0;
			hi_khz = FREQ_MAX;
			owner = 0;
			tab_len = 0;
			peak = 0;
			fail_count = 0;
			choice_q.delete();
			for (int i = 0; i < CORES; i++) begin
				last_wall[i] = 0;
				last_idle[i] = 0;
			end
			for (int i = 0; i < DEPTH; i++) begin
				tab_ok[i] = 0;
				freq_tab[i] = 0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_FREQ:  lo_khz = cfg_data;
					CFG_MAX_FREQ:  hi_khz = cfg_data;
					CFG_OWNER:     owner = cfg_data[2:0];
					CFG_TABLE_LEN: tab_len = cfg_data[4:0];
				endcase
			end
			if (out_mon.valid && out_mon.ready) begin
				if (choice_q.size() == 0) begin
					report("unexpected choice", 32'(out_mon.data.next_freq_khz), 0);
				end else begin
					lbfs_out_t w;
					w = choice_q.pop_front();
					if (out_mon.data.next_freq_khz !== w.next_freq_khz)
						report("next_freq_khz", 32'(out_mon.data.next_freq_khz),
							32'(w.next_freq_khz));
					if (out_mon.data.change_request !== w.change_request)
						report("change_request", 32'(out_mon.data.change_request),
							32'(w.change_request));
					if (out_mon.data.peak_load !== w.peak_load)
						report("peak_load", 32'(out_mon.data.peak_load), 32'(w.peak_load));
				end
			end
			if (in_mon.valid && in_mon.ready) take_sample(in_mon.data);
		end
	end
endmodule

// ===== verif/load_based_frequency_selector_test.sv =====
// Testbench top: drives samples, table writes and registers; gives the verdict.
module load_based_frequency_selector_test;
	import lbfs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IN_W = $bits(lbfs_in_t);

	logic                  clk, arst_n, cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count, pending, burst;
	logic [CNT_W-1:0]      wall_base [8], idle_base [8];
	logic [FREQ_W-1:0]     ladder [16];

	lbfs_in_if  in_ch ();
	lbfs_out_if out_ch ();

	load_based_frequency_selector u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	lbfs_checker u_checker (
		.clk(clk), .arst_n(arst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("load_based_frequency_selector_test: errors");
		$finish;
	end

	// receiver stall pattern: alternating runs of steady ready and random stalls
	initial begin
		int mode;
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			mode = int'(($time / 2000) % 3);
			if (mode == 0) out_ch.ready <= 1;
			else if (mode == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
			else out_ch.ready <= ($urandom_range(0, 4) == 0);
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	// send one transaction; valid stays up within a burst
	task automatic send(input lbfs_in_t t);
		if (burst <= 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst = $urandom_range(1, 12);
		end
		in_ch.valid <= 1;
		in_ch.data <= t;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		burst--;
		@(negedge clk);
		if (burst <= 0) in_ch.valid <= 0;
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		burst = 0;
		while (pending != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	function automatic lbfs_in_t rand_item();
		lbfs_in_t t;
		t = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		return t;
	endfunction

	task automatic send_table(input logic [3:0] idx, input logic [FREQ_W-1:0] f,
			input logic ok);
		lbfs_in_t t;
		t = rand_item();
		t.func = FUNC_TABLE;
		t.table_index = idx;
		t.table_freq_khz = f;
		t.table_entry_valid = ok;
		send(t);
	endtask

	// sample: counters mostly advance by a bounded step with idle below wall, at times by random steps
	task automatic send_core(input logic [2:0] core, input logic last,
			input logic [FREQ_W-1:0] cur);
		lbfs_in_t    t;
		logic [31:0] dw, di;
		t = rand_item();
		t.func = FUNC_SAMPLE;
		t.core_index = core;
		dw = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 100000);
		di = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, dw);
		wall_base[core] = wall_base[core] + CNT_W'(dw);
		idle_base[core] = idle_base[core] + CNT_W'(di);
		t.wall_time_now = wall_base[core];
		t.idle_time_now = idle_base[core];
		t.core_enabled = $urandom_range(0, 7) != 0;
		t.round_last = last;
		t.cur_freq_khz = cur;
		send(t);
	endtask

	task automatic load_ladder(input int n, input logic [FREQ_W-1:0] top);
		logic [FREQ_W-1:0] f;
		f = $urandom_range(0, 3) == 0 ? '0 : FREQ_W'($urandom_range(1, 20000));
		for (int i = 0; i < 16; i++) begin
			ladder[i] = f;
			send_table(i[3:0], f, $urandom_range(0, 5) != 0);
			f = FREQ_W'(32'(f) + $urandom_range(1, 1 + 32'(top) / 16));
		end
		drain();
		write_reg(CFG_TABLE_LEN, CFG_DATA_W'(n[4:0]));
	endtask

	task automatic pick_cur(output logic [FREQ_W-1:0] cur);
		case ($urandom_range(0, 4))
			0: cur = ladder[4'($urandom_range(0, 15))];
			1: cur = FREQ_MAX;
			2: cur = FREQ_W'(1);
			default: cur = FREQ_W'($urandom_range(1, 4194303));
		endcase
		if (cur == 0 && $urandom_range(0, 1)) cur = FREQ_W'(1);
	endtask

	initial begin
		lbfs_in_t          t;
		logic [FREQ_W-1:0] cur;
		int                count;
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_MIN_FREQ;
		cfg_data = 0;
		in_ch.valid = 0;
		in_ch.data = '0;
		burst = 0;
		for (int i = 0; i < 8; i++) begin
			wall_base[i] = 0;
			idle_base[i] = 0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: empty table, extremes, unknown current, disabled, skip cases
		t = '0;
		t.round_last = 1;
		t.cur_freq_khz = 5;
		t.core_enabled = 1;
		t.wall_time_now = 100;
		t.idle_time_now = 0;
		send(t);
		t.cur_freq_khz = 0;
		send(t);
		t = '1;
		t.func = FUNC_SAMPLE;
		send(t);
		t.core_index = 0;
		t.wall_time_now = 64'hFFFF_FFFF_0000_0000;
		send(t);
		t.idle_time_now = 64'h1;
		t.wall_time_now = 64'h0;
		t.round_last = 1;
		send(t);
		t.core_enabled = 0;
		t.cur_freq_khz = FREQ_MAX;
		send(t);
		send_table(4'd0, '0, 1);
		send_table(4'd15, FREQ_MAX, 1);
		send_table(4'd1, FREQ_MAX, 0);
		drain();
		write_reg(CFG_TABLE_LEN, CFG_DATA_W'(31));
		write_reg(CFG_MIN_FREQ, FREQ_MAX);
		write_reg(CFG_MAX_FREQ, '0);
		write_reg(CFG_OWNER, CFG_DATA_W'(7));
		send_core(3'd7, 1'b1, 22'd3);
		send_core(3'd0, 1'b1, FREQ_MAX);
		drain();

		// random phases across register settings
		count = 0;
		for (int ph = 0; ph < 24; ph++) begin
			write_reg(CFG_OWNER, ph < 2 ? CFG_DATA_W'(ph * 7) :
				CFG_DATA_W'($urandom_range(0, 7)));
			write_reg(CFG_MIN_FREQ, ph == 2 ? FREQ_MAX :
				($urandom_range(0, 2) == 0 ? '0 : CFG_DATA_W'($urandom_range(0, 300000))));
			write_reg(CFG_MAX_FREQ, ph == 3 ? '0 : (ph == 4 ? FREQ_MAX :
				CFG_DATA_W'($urandom_range(100000, 4194303))));
			load_ladder(ph == 5 ? 0 : (ph == 6 ? 16 : $urandom_range(0, 20)),
				FREQ_W'($urandom_range(1000, 4194303)));
			for (int k = 0; k < 70; k++) begin
				pick_cur(cur);
				if ($urandom_range(0, 19) == 0) begin
					t = rand_item();
					send(t);
				end else begin
					send_core(3'($urandom_range(0, 7)), $urandom_range(0, 3) == 0, cur);
				end
				count++;
			end
			drain();
		end

		if (fail_count == 0) begin
			$display("load_based_frequency_selector_test: clean");
		end else begin
			$display("load_based_frequency_selector_test: errors");
		end
		$finish;
	end
endmodule

// ===== load_based_frequency_selector.f =====
rtl/lbfs_pkg.sv
rtl/lbfs_in_if.sv
rtl/lbfs_out_if.sv
rtl/load_based_frequency_selector.sv
verif/lbfs_checker.sv
verif/load_based_frequency_selector_test.sv
